>>> rtl/core/eaic_pkg.sv
// Shared types and constants for the Ethernet ARP/IP receive classifier.
// No dependencies; every module of the classifier imports this package.
`default_nettype none

package eaic_pkg;

   // frame byte counter, saturates at its all-ones value
   localparam int COUNT_BITS = 11;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // verdict queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // configuration register indexes
   localparam logic CSR_OWN_MAC = 1'b0;
   localparam logic CSR_OWN_IP  = 1'b1;

   localparam logic [47:0] OWN_MAC_RESET = 48'h0;
   localparam logic [31:0] OWN_IP_RESET  = 32'h0A00_0001;

   // ethertypes, ARP and IP codes
   localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
   localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
   localparam logic [15:0] ARP_OP_REPLY   = 16'd2;
   localparam logic [7:0]  ARP_HW_SIZE    = 8'd6;
   localparam logic [7:0]  ARP_PROTO_SIZE = 8'd4;
   localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
   localparam logic [7:0]  IP_PROTO_ICMP  = 8'd1;
   localparam logic [7:0]  ICMP_TYPE_PING       = 8'd8;
   localparam logic [7:0]  ICMP_TYPE_PING_REPLY = 8'd0;

   // verdict codes
   localparam logic [3:0] VERDICT_BAD_SOURCE     = 4'd0;
   localparam logic [3:0] VERDICT_NOT_FOR_ME     = 4'd1;
   localparam logic [3:0] VERDICT_UNKNOWN_TYPE   = 4'd2;
   localparam logic [3:0] VERDICT_ARP_MALFORMED  = 4'd3;
   localparam logic [3:0] VERDICT_ARP_NOT_FOR_ME = 4'd4;
   localparam logic [3:0] VERDICT_ARP_REQUEST    = 4'd5;
   localparam logic [3:0] VERDICT_ARP_REPLY      = 4'd6;
   localparam logic [3:0] VERDICT_UDP            = 4'd7;
   localparam logic [3:0] VERDICT_ICMP_PING      = 4'd8;
   localparam logic [3:0] VERDICT_ICMP_REPLY     = 4'd9;
   localparam logic [3:0] VERDICT_ICMP_OTHER     = 4'd10;
   localparam logic [3:0] VERDICT_IP_UNREG       = 4'd11;
   localparam logic [3:0] VERDICT_TRUNCATED      = 4'd12;

   typedef struct packed {
      logic [31:0] peer_ip;
      logic [47:0] peer_mac;
      logic [3:0]  verdict;
   } result_type;

   // one queue word with its valid flag
   typedef struct packed {
      logic       valid;
      result_type data;
   } result_word_type;

endpackage

`default_nettype wire

>>> rtl/core/eaic_front.sv
// Front end: per-byte field capture and end-of-frame classification.
// Depends on eaic_pkg; pushes one verdict word per frame into eaic_queue.
`default_nettype none

module eaic_front import eaic_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            byte_valid,
   input  wire logic [7:0]      data_byte,
   input  wire logic            last,
   input  wire logic            queue_full,
   input  wire logic [47:0]     own_mac,
   input  wire logic [31:0]     own_ip,
   output logic                 byte_ready,
   output result_word_type      push
);

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic        dest_ok_ff, dest_ok_in;
   logic        dest_bcast_ff, dest_bcast_in;
   logic [47:0] source_mac_ff, source_mac_in;
   logic [15:0] ether_type_ff, ether_type_in;
   logic [47:0] arp_fields_ff, arp_fields_in;
   logic [47:0] sender_mac_ff, sender_mac_in;
   logic [31:0] sender_ip_ff, sender_ip_in;
   logic [31:0] target_ip_ff, target_ip_in;
   logic [7:0]  ip_protocol_ff, ip_protocol_in;
   logic [7:0]  icmp_kind_ff, icmp_kind_in;

   logic [COUNT_BITS-1:0] pos;
   logic [2:0]  mac_byte_idx;
   logic [7:0]  mine;
   logic        accept;
   logic [15:0] arp_ptype, arp_op;
   logic [7:0]  arp_hsize, arp_psize;
   logic        arp_bad;
   result_type  result;

   assign byte_ready   = !queue_full;
   assign accept       = byte_valid && byte_ready;
   assign pos          = count_ff;
   assign mac_byte_idx = 3'd5 - pos[2:0];
   assign mine         = own_mac[{mac_byte_idx, 3'b000} +: 8];

   // capture the current byte into the field it belongs to
   always_comb begin
      dest_ok_in     = dest_ok_ff;
      dest_bcast_in  = dest_bcast_ff;
      source_mac_in  = source_mac_ff;
      ether_type_in  = ether_type_ff;
      arp_fields_in  = arp_fields_ff;
      sender_mac_in  = sender_mac_ff;
      sender_ip_in   = sender_ip_ff;
      target_ip_in   = target_ip_ff;
      ip_protocol_in = ip_protocol_ff;
      icmp_kind_in   = icmp_kind_ff;
      if (pos < COUNT_BITS'(6)) begin
         if (data_byte != 8'hFF) dest_bcast_in = 1'b0;
         if (data_byte != mine) dest_ok_in = 1'b0;
      end else if (pos < COUNT_BITS'(12)) begin
         source_mac_in = {source_mac_ff[39:0], data_byte};
      end else if (pos < COUNT_BITS'(14)) begin
         ether_type_in = {ether_type_ff[7:0], data_byte};
      end else if (ether_type_ff == ETH_TYPE_ARP) begin
         if (pos >= COUNT_BITS'(16) && pos < COUNT_BITS'(22)) begin
            arp_fields_in = {arp_fields_ff[39:0], data_byte};
         end else if (pos >= COUNT_BITS'(22) && pos < COUNT_BITS'(28)) begin
            sender_mac_in = {sender_mac_ff[39:0], data_byte};
         end else if (pos >= COUNT_BITS'(28) && pos < COUNT_BITS'(32)) begin
            sender_ip_in = {sender_ip_ff[23:0], data_byte};
         end else if (pos >= COUNT_BITS'(38) && pos < COUNT_BITS'(42)) begin
            target_ip_in = {target_ip_ff[23:0], data_byte};
         end
      end else if (ether_type_ff == ETH_TYPE_IPV4) begin
         if (pos == COUNT_BITS'(23)) begin
            ip_protocol_in = data_byte;
         end else if (pos >= COUNT_BITS'(26) && pos < COUNT_BITS'(30)) begin
            sender_ip_in = {sender_ip_ff[23:0], data_byte};
         end else if (pos == COUNT_BITS'(34)) begin
            icmp_kind_in = data_byte;
         end
      end
      count_in = (count_ff != COUNT_MAX) ? count_ff + COUNT_BITS'(1) : count_ff;
   end

   assign arp_ptype = arp_fields_in[47:32];
   assign arp_hsize = arp_fields_in[31:24];
   assign arp_psize = arp_fields_in[23:16];
   assign arp_op    = arp_fields_in[15:0];
   assign arp_bad   = (count_in < COUNT_BITS'(60)) || (arp_hsize != ARP_HW_SIZE) ||
                      (arp_psize != ARP_PROTO_SIZE) || (arp_ptype != ETH_TYPE_IPV4) ||
                      ((arp_op != ARP_OP_REQUEST) && (arp_op != ARP_OP_REPLY));

   // verdict of the frame that ends with this byte
   always_comb begin
      result.peer_mac = source_mac_in;
      result.peer_ip  = 32'h0;
      result.verdict  = VERDICT_UNKNOWN_TYPE;
      if (count_in < COUNT_BITS'(12)) begin
         result.verdict = VERDICT_TRUNCATED;
      end else if (source_mac_in[40] || source_mac_in == 48'h0) begin
         result.verdict = VERDICT_BAD_SOURCE;
      end else if (!dest_bcast_in && !dest_ok_in) begin
         result.verdict = VERDICT_NOT_FOR_ME;
      end else if (count_in < COUNT_BITS'(14)) begin
         result.verdict = VERDICT_TRUNCATED;
      end else if (ether_type_in == ETH_TYPE_ARP) begin
         result.peer_mac = sender_mac_in;
         if (arp_bad) begin
            result.verdict = VERDICT_ARP_MALFORMED;
         end else begin
            result.peer_ip = sender_ip_in;
            if (own_ip == 32'h0 || own_ip != target_ip_in) begin
               result.verdict = VERDICT_ARP_NOT_FOR_ME;
            end else if (arp_op == ARP_OP_REQUEST) begin
               result.verdict = VERDICT_ARP_REQUEST;
            end else begin
               result.verdict = VERDICT_ARP_REPLY;
            end
         end
      end else if (ether_type_in == ETH_TYPE_IPV4) begin
         if (count_in < COUNT_BITS'(30)) begin
            result.verdict = VERDICT_TRUNCATED;
         end else if (ip_protocol_in == IP_PROTO_UDP) begin
            result.peer_ip = sender_ip_in;
            result.verdict = VERDICT_UDP;
         end else if (ip_protocol_in == IP_PROTO_ICMP) begin
            if (count_in < COUNT_BITS'(35)) begin
               result.verdict = VERDICT_TRUNCATED;
            end else begin
               result.peer_ip = sender_ip_in;
               if (icmp_kind_in == ICMP_TYPE_PING) begin
                  result.verdict = VERDICT_ICMP_PING;
               end else if (icmp_kind_in == ICMP_TYPE_PING_REPLY) begin
                  result.verdict = VERDICT_ICMP_REPLY;
               end else begin
                  result.verdict = VERDICT_ICMP_OTHER;
               end
            end
         end else begin
            result.peer_ip = sender_ip_in;
            result.verdict = VERDICT_IP_UNREG;
         end
      end
   end

   assign push.valid = accept && last;
   assign push.data  = result;

   // clear all frame state after reset and after each last byte
   always_ff @(posedge clock) begin
      if (reset || (accept && last)) begin
         count_ff       <= '0;
         dest_ok_ff     <= 1'b1;
         dest_bcast_ff  <= 1'b1;
         source_mac_ff  <= 48'h0;
         ether_type_ff  <= 16'h0;
         arp_fields_ff  <= 48'h0;
         sender_mac_ff  <= 48'h0;
         sender_ip_ff   <= 32'h0;
         target_ip_ff   <= 32'h0;
         ip_protocol_ff <= 8'h0;
         icmp_kind_ff   <= 8'h0;
      end else if (accept) begin
         count_ff       <= count_in;
         dest_ok_ff     <= dest_ok_in;
         dest_bcast_ff  <= dest_bcast_in;
         source_mac_ff  <= source_mac_in;
         ether_type_ff  <= ether_type_in;
         arp_fields_ff  <= arp_fields_in;
         sender_mac_ff  <= sender_mac_in;
         sender_ip_ff   <= sender_ip_in;
         target_ip_ff   <= target_ip_in;
         ip_protocol_ff <= ip_protocol_in;
         icmp_kind_ff   <= icmp_kind_in;
      end
   end

`ifndef SYNTHESIS
   a_count_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |=> (count_ff == '0))
      else $error("byte counter not cleared after last byte");
`endif

endmodule

`default_nettype wire

>>> rtl/core/eaic_queue.sv
// Short verdict queue decoupling the classifier front from the output stage.
// Depends on eaic_pkg for the word type and depth.
`default_nettype none

module eaic_queue import eaic_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire result_word_type push,
   input  wire logic      pop,
   output logic           full,
   output result_word_type head
);

   result_type entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic do_pop;

   assign full       = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.data  = entries_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      if (push.valid && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_BITS'(1);
      end else if (do_pop && !push.valid) begin
         count_in = count_ff - QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.data;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("verdict pushed into a full queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
      else $error("queue occupancy above depth");
`endif

endmodule

`default_nettype wire

>>> rtl/core/eaic_back.sv
// Back end: output register that presents one verdict word at a time.
// Depends on eaic_pkg; drains eaic_queue.
`default_nettype none

module eaic_back import eaic_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire result_word_type head,
   output logic             pop,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [87:0]      rsp_tdata   // verdict[3:0], peer_mac[51:4], peer_ip[83:52], zeros
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   // advance when the register is empty or its word is being taken
   assign pop      = head.valid && (!valid_ff || rsp_tready);
   assign valid_in = pop || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= head.data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'b0000, data_ff.peer_ip, data_ff.peer_mac, data_ff.verdict};

`ifndef SYNTHESIS
   a_pop_only_when_free: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!valid_ff || rsp_tready))
      else $error("output register overwritten while holding a word");
`endif

endmodule

`default_nettype wire

>>> rtl/core/ethernet_arp_ip_rx_classifier.sv
// The verdict word reaches rsp through the queue entry and then the output register.
// Throughput: one byte per cycle unless the queue is full, set by the front's byte capture.
// The two-entry queue plus output register keep bytes flowing while rsp stalls, until full.
// Reset (synchronous, active high): clears frame state, queue and output valid;
// own_mac returns to zero and own_ip to 10.0.0.1. No clearing pass is needed.
`default_nettype none

module ethernet_arp_ip_rx_classifier import eaic_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   // frame bytes in
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte[7:0]
   input  wire logic        req_tlast,   // last byte of the frame
   // verdicts out
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [87:0]      rsp_tdata,   // verdict[3:0], peer_mac[51:4], peer_ip[83:52], zeros
   // register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [47:0] csr_data
);

   logic [47:0] own_mac_ff;
   logic [31:0] own_ip_ff;
   logic        queue_full;
   logic        queue_pop;
   result_word_type push_word;
   result_word_type head_word;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff <= OWN_MAC_RESET;
         own_ip_ff  <= OWN_IP_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_OWN_MAC: own_mac_ff <= csr_data;
            CSR_OWN_IP:  own_ip_ff  <= csr_data[31:0];
            default:     own_mac_ff <= own_mac_ff;
         endcase
      end
   end

   // front: capture bytes, classify at the last byte, push one verdict word
   eaic_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .data_byte  (req_tdata),
      .last       (req_tlast),
      .queue_full (queue_full),
      .own_mac    (own_mac_ff),
      .own_ip     (own_ip_ff),
      .byte_ready (req_tready),
      .push       (push_word)
   );

   // hold verdicts while the consumer stalls
   eaic_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push_word),
      .pop   (queue_pop),
      .full  (queue_full),
      .head  (head_word)
   );

   // back: drive the result channel from its own register
   eaic_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head_word),
      .pop        (queue_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
